// ===== hw/rtl/sida_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sida_pkg
// Shared types and constants for the signed integer to decimal ASCII core.
// ----------------------------------------------------------------------------
package sida_pkg;

  localparam int unsigned MagWidth  = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned CharWidth = 8;
  localparam int unsigned IdxWidth  = $clog2(NumDigits);
  localparam int unsigned CntWidth  = $clog2(MagWidth);

  localparam logic [CharWidth-1:0] CharZero  = 8'h30;
  localparam logic [CharWidth-1:0] CharMinus = 8'h2D;

  typedef logic [NumDigits-1:0][3:0] bcd_t;

  // Request into the binary-to-BCD unit.
  typedef struct packed {
    logic                start;
    logic [MagWidth-1:0] mag;
  } conv_req_t;

  // Response from the binary-to-BCD unit.
  typedef struct packed {
    logic done;
    logic busy;
    bcd_t bcd;
  } conv_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sida_bcd_conv.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sida_bcd_conv
// Iterative shift-and-add-3 converter: one binary bit per cycle into ten BCD
// digits.
// ----------------------------------------------------------------------------
module sida_bcd_conv (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  sida_pkg::conv_req_t  req_i,
  output sida_pkg::conv_rsp_t  rsp_o
);

  logic [sida_pkg::MagWidth-1:0] bin_q, bin_d;
  sida_pkg::bcd_t                bcd_q, bcd_d, bcd_adj;
  logic [sida_pkg::CntWidth-1:0] cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;

  // Bump every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < sida_pkg::NumDigits; i++) begin
      bcd_adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      bin_d  = req_i.mag;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = sida_pkg::bcd_t'({bcd_adj, bin_q[sida_pkg::MagWidth-1]});
      bin_d = {bin_q[sida_pkg::MagWidth-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == sida_pkg::CntWidth'(sida_pkg::MagWidth - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.bcd  = bcd_q;

endmodule
`default_nettype wire

// ===== hw/rtl/signed_int_to_decimal_ascii_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Each accepted number yields n characters (1 to 11); the 32-step
// shift-and-add-3 loop of the BCD unit runs before the first one is loaded.
// Input is ready again once the final character sits in the output register.
// Reset is asynchronous, active low, and returns the core to idle with no
// pending output.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  // slave side: tdata = number[31:0]
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,
  // master side: tdata = character[7:0]; tlast = last_char
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast
);

  // Sequencer states.
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StConv  = 2'd1;
  localparam logic [1:0] StSign  = 2'd2;
  localparam logic [1:0] StDigit = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic                          neg_q, neg_d;
  sida_pkg::bcd_t                digits_q, digits_d;
  logic [sida_pkg::IdxWidth-1:0] pos_q, pos_d;
  logic [sida_pkg::IdxWidth-1:0] lead_idx;

  logic                           out_valid_q, out_valid_d;
  logic [sida_pkg::CharWidth-1:0] out_char_q, out_char_d;
  logic                           out_last_q, out_last_d;

  logic                slot_free;
  logic                in_xfer;
  logic                load_last;
  sida_pkg::conv_req_t conv_req;
  sida_pkg::conv_rsp_t conv_rsp;

  // Accept a new number only while idle.
  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Output register is free when empty or being drained this cycle.
  assign slot_free = !out_valid_q || m_axis_tready;

  // Convert the unsigned magnitude; the most negative value maps to 2^31.
  assign conv_req.start = in_xfer;
  assign conv_req.mag   = s_axis_tdata[31] ? (32'd0 - s_axis_tdata) : s_axis_tdata;

  sida_bcd_conv u_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (conv_req),
    .rsp_o  (conv_rsp)
  );

  // Most significant nonzero digit; zero leaves index 0 so one '0' goes out.
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < sida_pkg::NumDigits; i++) begin
      if (conv_rsp.bcd[i] != 4'd0) begin
        lead_idx = sida_pkg::IdxWidth'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    digits_d    = digits_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    load_last   = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          neg_d   = s_axis_tdata[31];
          state_d = StConv;
        end
      end
      StConv: begin
        // Capture the digits and skip the leading zeros in one step.
        if (conv_rsp.done) begin
          digits_d = conv_rsp.bcd;
          pos_d    = lead_idx;
          state_d  = neg_q ? StSign : StDigit;
        end
      end
      StSign: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = sida_pkg::CharMinus;
          out_last_d  = 1'b0;
          state_d     = StDigit;
        end
      end
      StDigit: begin
        // Emit one digit per free slot, most significant first.
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = sida_pkg::CharZero + {4'd0, digits_q[pos_q]};
          out_last_d  = (pos_q == '0);
          if (pos_q == '0) begin
            load_last = 1'b1;
            state_d   = StIdle;
          end else begin
            pos_d = pos_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk_i) begin
    neg_q      <= neg_d;
    digits_q   <= digits_d;
    pos_q      <= pos_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // The BCD unit finishes only while the sequencer waits for it.
  a_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_rsp.done |-> (state_q == StConv))
    else $error("conversion finished outside the convert state");

  // An accepted number always starts the BCD unit.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (conv_rsp.busy && state_q == StConv))
    else $error("accepted number did not start a conversion");

  // A minus sign is never the final character.
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata == sida_pkg::CharMinus) |-> !m_axis_tlast)
    else $error("minus sign marked as last character");

  // Loading the final character returns the core to idle with it pending.
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_last |=> (state_q == StIdle && m_axis_tvalid && m_axis_tlast))
    else $error("final character did not close the transaction sequence");

endmodule
`default_nettype wire

// ===== verif/tb_signed_int_to_decimal_ascii_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_core
// Self-checking bench for the signed integer to decimal ASCII core. Numbers go
// in on the slave stream, and the bench queues each one's characters (typed in
// or forecast) and compares every master-side transaction against the oldest. A short
// table of edge values leads, then random numbers of every length, under
// shifting idle patterns on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii_core;

  localparam int unsigned HalfPeriod = 10;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned HoldCycles = 400;
  // Settle time after the last character.
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned MaxErrorLines = 40;
  localparam int unsigned DirectedRows = 20;

  // One character on the output stream.
  typedef struct {
    logic [sida_pkg::CharWidth-1:0] code;
    logic                           last;
  } ascii_char_t;

  // One row of the edge-value table; an empty text means "forecast it".
  typedef struct {
    logic [sida_pkg::MagWidth-1:0] number;
    string                         text;
  } stim_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [sida_pkg::MagWidth-1:0]  s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [sida_pkg::CharWidth-1:0] m_axis_tdata;
  logic                           m_axis_tlast;

  // Characters still owed by the core, oldest first.
  ascii_char_t pending_chars[$];
  // Typed-in text for each offered number, in offer order ("" when forecast).
  string       offered_text[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  stim_row_t   directed_rows[DirectedRows];

  signed_int_to_decimal_ascii_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // number[31:0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // character[7:0]
    .m_axis_tlast  (m_axis_tlast)    // last_char
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MaxErrorLines) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Forecast the text of one number: sign, then digits of the unsigned
  // magnitude, most significant first, tlast on the final digit.
  function automatic void forecast_decimal(input logic [sida_pkg::MagWidth-1:0] number);
    logic [sida_pkg::MagWidth-1:0] mag;
    logic [3:0]                    digs[sida_pkg::NumDigits];
    int                            nd;
    mag = number[sida_pkg::MagWidth-1] ? (~number + 1'b1) : number;
    nd = 0;
    do begin
      digs[nd] = 4'(mag % 10);
      mag = mag / 10;
      nd++;
    end while (mag != 0);
    if (number[sida_pkg::MagWidth-1]) pending_chars.push_back('{sida_pkg::CharMinus, 1'b0});
    for (int i = nd - 1; i >= 0; i--) begin
      pending_chars.push_back('{sida_pkg::CharZero + sida_pkg::CharWidth'(digs[i]), i == 0});
    end
  endfunction

  // Queue a typed-in text as expected characters.
  function automatic void expect_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      pending_chars.push_back('{text[i], i == text.len() - 1});
    end
  endfunction

  // Record accepted numbers, then check every character that leaves.
  always @(posedge clk_i) begin : stream_monitor
    string       text;
    ascii_char_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        text = offered_text.pop_front();
        if (text.len() != 0) expect_text(text);
        else forecast_decimal(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_chars.size() == 0) begin
          flag_error($sformatf("unexpected character %h last %b", m_axis_tdata, m_axis_tlast));
        end else begin
          want = pending_chars.pop_front();
          if (m_axis_tdata !== want.code)
            flag_error($sformatf("character %h, want %h", m_axis_tdata, want.code));
          if (m_axis_tlast !== want.last)
            flag_error($sformatf("tlast %b on %h, want %b", m_axis_tlast, m_axis_tdata, want.last));
        end
      end
    end
  end

  // Output side: random back-pressure, plus one long hold-off on request so
  // the core fills up and stalls its input.
  always @(posedge clk_i) begin : output_pacer
    int unsigned hold_left;
    if (hold_req && !hold_taken) begin
      hold_left = HoldCycles;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one number; hold tvalid high across back-to-back transactions so it
  // never drops and rises within one step.
  task automatic offer_number(input logic [sida_pkg::MagWidth-1:0] number, input string text);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    offered_text.push_back(text);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= number;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Pick a number: mostly a random digit count and sign, sometimes a raw word,
  // now and then one of the extremes.
  function automatic logic [sida_pkg::MagWidth-1:0] pick_number();
    logic [sida_pkg::MagWidth-1:0] lo;
    logic [sida_pkg::MagWidth-1:0] hi;
    logic [sida_pkg::MagWidth-1:0] mag;
    int unsigned                   ndig;
    case ($urandom_range(7))
      0: return $urandom;
      1: begin
        case ($urandom_range(3))
          0: return 32'h0000_0000;
          1: return 32'h8000_0000;
          2: return 32'h7FFF_FFFF;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        ndig = $urandom_range(sida_pkg::NumDigits, 1);
        lo = 1;
        for (int i = 1; i < ndig; i++) lo = lo * 10;
        hi = (ndig == sida_pkg::NumDigits) ? 32'h7FFF_FFFF : lo * 10 - 1;
        if (ndig == 1) lo = 0;
        mag = $urandom_range(hi, lo);
        return $urandom_range(1) ? (~mag + 1'b1) : mag;
      end
    endcase
  endfunction

  task automatic offer_random(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) offer_number(pick_number(), "");
  endtask

  initial begin
    directed_rows = '{
      '{32'd0,          "0"},
      '{32'd1,          "1"},
      '{32'hFFFF_FFFF,  "-1"},
      '{32'd9,          "9"},
      '{32'd10,         "10"},
      '{32'hFFFF_FFF6,  "-10"},
      '{32'hFFFF_FFFB,  "-5"},
      '{32'd99,         ""},
      '{32'd100,        ""},
      '{32'h7FFF_FFFF,  "2147483647"},
      '{32'h8000_0000,  "-2147483648"},
      '{32'h8000_0001,  "-2147483647"},
      '{32'd1000000000, "1000000000"},
      '{32'd999999999,  "999999999"},
      '{32'hC465_3601,  "-999999999"},
      '{32'd123456789,  "123456789"},
      '{32'h5555_5555,  ""},
      '{32'hAAAA_AAAA,  ""},
      '{32'h0000_FFFF,  ""},
      '{32'hFFFF_0000,  ""}
    };

    // Hold reset, then release on an edge.
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender mostly busy, receiver mostly idle.
    send_idle_pct = 25;
    recv_idle_pct <= 79;
    foreach (directed_rows[i]) offer_number(directed_rows[i].number, directed_rows[i].text);
    offer_random(150);

    // Swap the idle pattern.
    send_idle_pct = 79;
    recv_idle_pct <= 25;
    offer_random(150);

    // No idling; open with a long output hold-off while input keeps coming.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_req <= 1'b1;
    offer_random(170);
    s_axis_tvalid <= 1'b0;

    // Drain the output, then give stray characters a chance to show up.
    while (pending_chars.size() != 0 || offered_text.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_chars.size() != 0)
      flag_error($sformatf("%0d characters never arrived", pending_chars.size()));

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
